/* rtl/seecr_pkg.sv */
`default_nettype none

package seecr_pkg;

  // store geometry; STORE_BYTES must be a power of two in 512..2048
  localparam int unsigned STORE_BYTES = 2048;
  localparam int unsigned STORE_AW    = $clog2(STORE_BYTES);
  localparam int unsigned PAGE_W      = STORE_AW - 3;

  // command bytes
  localparam logic [7:0] CMD_READ  = 8'h04;
  localparam logic [7:0] CMD_WRITE = 8'h05;
  localparam logic [7:0] CMD_ID0   = 8'h00;
  localparam logic [7:0] CMD_ID1   = 8'hFF;

  localparam logic [23:0] ID_RESET    = 24'h008000;
  localparam logic [31:0] TICKS_RESET = 32'd30000000;

  // register select (paddr bit 2)
  localparam logic REG_ID    = 1'b0;
  localparam logic REG_TICKS = 1'b1;

  // request kinds
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_PRELOAD = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_READ_PAGE,
    PH_WRITE_PAGE,
    PH_WRITE_DATA
  } phase_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_READ,
    CTL_ID
  } ctl_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  rx_byte;
    logic [10:0] preload_addr;
  } req_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
    logic       flush_request;
  } res_t;

endpackage

`default_nettype wire

/* rtl/serial_eeprom_command_responder_core.sv */
`default_nettype none

// Byte-level command responder for an emulated serial save EEPROM. A request is
// taken when start is high and busy is low; each result appears on res_o for a
// single cycle marked by res_valid_o, and the receiver has no way to hold it
// off, so it must sample every strobe. Idle ticks, preloads, write-page and
// write-data bytes and command bytes other than identity leave busy low; the
// final write-data byte strobes its 0x00 reply in the cycle after acceptance.
// The identity command keeps busy high while the sequencer steps through its
// three bytes. A read-page byte keeps busy high while the sequencer reads the
// page's eight bytes in turn through the store's single registered read port;
// they strobe from the read register, and the next request may be taken in
// the same cycle as the last one strobes. A flush request strobes in the cycle
// after the tick that found the store dirty. The store is not cleared at reset:
// it holds whatever was preloaded or written, so there is no startup sweep.
module serial_eeprom_command_responder_core
  import seecr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req_i,
  // result channel
  output logic             res_valid_o,
  output res_t             res_o,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [23:0] id_q;
  logic [31:0] ticks_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q    <= ID_RESET;
      ticks_q <= TICKS_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ID) begin
        id_q <= pwdata[23:0];
      end else begin
        ticks_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_TICKS) ? ticks_q : {8'h00, id_q};

  // ---------------------------------------------------------------------------
  // Command state
  // ---------------------------------------------------------------------------
  phase_e              phase_q, phase_d;
  logic [PAGE_W-1:0]   page_q, page_d;     // page of the write in progress
  logic [2:0]          idx_q, idx_d;       // byte within that page
  logic                dirty_q, dirty_d;
  logic [31:0]         idle_q, idle_d;
  logic [31:0]         idle_inc;

  // sequencer for multi-byte replies
  ctl_e                ctl_q, ctl_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [PAGE_W-1:0]   rd_page_q, rd_page_d;

  // registered single-result output (id bytes, write ack, flush)
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  // store access
  logic                mem_we;
  logic [STORE_AW-1:0] mem_waddr;
  logic [7:0]          mem_wdata;
  logic                mem_re;
  logic [STORE_AW-1:0] mem_raddr;
  logic [7:0]          mem_rdata_q;
  logic                rd_valid_q, rd_last_q;

  logic                accept;
  logic                go_read, go_id;
  logic                seq_done;

  assign accept   = start & ~busy;
  assign idle_inc = idle_q + 32'd1;

  // request decode and command parser
  always_comb begin
    phase_d     = phase_q;
    page_d      = page_q;
    idx_d       = idx_q;
    dirty_d     = dirty_q;
    idle_d      = idle_q;
    rd_page_d   = rd_page_q;
    out_valid_d = 1'b0;
    out_d       = '0;
    mem_we      = 1'b0;
    mem_waddr   = req_i.preload_addr[STORE_AW-1:0];
    mem_wdata   = req_i.rx_byte;
    go_read     = 1'b0;
    go_id       = 1'b0;

    if (accept) begin
      unique case (req_i.req_type)
        REQ_BYTE: begin
          unique case (phase_q)
            PH_READ_PAGE: begin
              rd_page_d = req_i.rx_byte[PAGE_W-1:0];
              go_read   = 1'b1;
              phase_d   = PH_IDLE;
            end
            PH_WRITE_PAGE: begin
              page_d  = req_i.rx_byte[PAGE_W-1:0];
              idx_d   = 3'd0;
              phase_d = PH_WRITE_DATA;
            end
            PH_WRITE_DATA: begin
              mem_we    = 1'b1;
              mem_waddr = {page_q, idx_q};
              idx_d     = idx_q + 3'd1;
              if (idx_q == 3'd7) begin
                phase_d           = PH_IDLE;
                out_valid_d       = 1'b1;
                out_d.reply_last  = 1'b1;
              end
            end
            default: begin
              case (req_i.rx_byte) inside
                CMD_READ: begin
                  idle_d  = '0;
                  phase_d = PH_READ_PAGE;
                end
                CMD_WRITE: begin
                  idle_d  = '0;
                  dirty_d = 1'b1;
                  phase_d = PH_WRITE_PAGE;
                end
                CMD_ID0, CMD_ID1: begin
                  idle_d = '0;
                  go_id  = 1'b1;
                end
                default: ;
              endcase
            end
          endcase
        end
        REQ_TICK: begin
          if (phase_q == PH_IDLE) begin
            idle_d = idle_inc;
            if (idle_inc >= ticks_q) begin
              idle_d = '0;
              if (dirty_q) begin
                dirty_d             = 1'b0;
                out_valid_d         = 1'b1;
                out_d.flush_request = 1'b1;
              end
            end
          end
        end
        REQ_PRELOAD: begin
          mem_we = 1'b1;
        end
        default: ;
      endcase
    end

    // identity bytes, most significant first
    if (ctl_q == CTL_ID) begin
      out_valid_d = 1'b1;
      unique case (cnt_q)
        3'd0:    out_d.reply_byte = id_q[23:16];
        3'd1:    out_d.reply_byte = id_q[15:8];
        default: out_d.reply_byte = id_q[7:0];
      endcase
      out_d.reply_last = (cnt_q == 3'd2);
    end
  end

  // sequencer: next state
  always_comb begin
    ctl_d = ctl_q;
    cnt_d = cnt_q;
    unique case (ctl_q)
      CTL_IDLE: begin
        cnt_d = 3'd0;
        if (go_read) begin
          ctl_d = CTL_READ;
        end else if (go_id) begin
          ctl_d = CTL_ID;
        end
      end
      CTL_READ, CTL_ID: begin
        cnt_d = cnt_q + 3'd1;
        if (seq_done) begin
          ctl_d = CTL_IDLE;
          cnt_d = 3'd0;
        end
      end
      default: ctl_d = CTL_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    busy      = (ctl_q != CTL_IDLE);
    mem_re    = (ctl_q == CTL_READ);
    mem_raddr = {rd_page_q, cnt_q};
    seq_done  = ((ctl_q == CTL_READ) && (cnt_q == 3'd7)) ||
                ((ctl_q == CTL_ID) && (cnt_q == 3'd2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      page_q      <= '0;
      idx_q       <= '0;
      dirty_q     <= 1'b0;
      idle_q      <= '0;
      ctl_q       <= CTL_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rd_valid_q  <= 1'b0;
      rd_last_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      page_q      <= page_d;
      idx_q       <= idx_d;
      dirty_q     <= dirty_d;
      idle_q      <= idle_d;
      ctl_q       <= ctl_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      rd_valid_q  <= mem_re;
      rd_last_q   <= mem_re & (cnt_q == 3'd7);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_page_q <= rd_page_d;
    out_q     <= out_d;
  end

  // save store: one write port, one registered read port
  logic [7:0] store_mem [STORE_BYTES];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= store_mem[mem_raddr];
    end
  end

  // result mux: page-read data and single results never share a cycle
  always_comb begin
    res_valid_o = out_valid_q | rd_valid_q;
    if (rd_valid_q) begin
      res_o.reply_byte    = mem_rdata_q;
      res_o.reply_last    = rd_last_q;
      res_o.flush_request = 1'b0;
    end else begin
      res_o = out_q;
    end
  end

`ifndef ASSERT_OFF
  a_no_result_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_valid_q && out_valid_q))
    else $error("page-read data and single result strobed together");

  a_read_holds_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.req_type == REQ_BYTE && phase_q == PH_READ_PAGE) |=> busy)
    else $error("page read accepted without entering the read sequence");

  a_read_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && rd_last_q) |=> !rd_valid_q)
    else $error("page-read data continued past its last byte");

  a_flush_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.flush_request) |-> (!res_o.reply_last && res_o.reply_byte == 8'h00))
    else $error("flush result carries reply data");
`endif

endmodule

`default_nettype wire

/* dv/tb_serial_eeprom_command_responder_core.sv */
`default_nettype none

// Testbench for the serial save-EEPROM command responder.
// Requests go in one per start/busy handshake, driven on the falling edge.
// Every accepted request runs through a behavioral shadow of the responder,
// and its replies are queued. Each res_valid_o strobe is checked against the
// oldest queued reply. Register writes happen only with the block drained.
module tb_serial_eeprom_command_responder_core;
  import seecr_pkg::*;

  // request kind with no meaning to the block; it must be dropped silently
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  // a byte that is not a command when the block is awaiting one
  localparam logic [7:0] CMD_UNKNOWN  = 8'h37;

  localparam logic [2:0] ADDR_ID    = {REG_ID, 2'b00};
  localparam logic [2:0] ADDR_TICKS = {REG_TICKS, 2'b00};

  // typed_n value for a request whose replies come from the shadow model
  localparam int BY_PREDICTION = -1;
  // a read page is the slowest request
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 46;
  localparam int PRELOAD_BYTES = 16;
  localparam int RUN_LIMIT     = 400000;

  typedef enum logic {
    STEP_REQ,
    STEP_CFG
  } step_e;

  // one row of the directed table; typed_n >= 0 means the replies are typed in
  typedef struct {
    step_e       kind;
    req_t        req;
    logic [2:0]  addr;
    logic [31:0] value;
    int          typed_n;
    logic [23:0] typed_bytes;
    logic        typed_flush;
  } step_t;

  logic        clk_i;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  req_t        req     = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        res_valid_o;
  res_t        res_o;
  logic [31:0] prdata;
  logic        pready;

  // shadow copy of the responder state and its registers
  logic [7:0]  shadow_store [STORE_BYTES];
  bit          shadow_known [STORE_BYTES];
  phase_e      shadow_phase;
  logic [7:0]  shadow_page;
  logic [2:0]  shadow_index;
  logic        shadow_dirty;
  logic [31:0] shadow_idle;
  logic [23:0] shadow_id;
  logic [31:0] shadow_ticks;

  res_t  pending_replies [$];
  step_t plan [$];
  int    mismatches = 0;
  int    requests_sent = 0;
  bit    gaps_on = 1'b1;

  serial_eeprom_command_responder_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic res_t make_reply(input logic [7:0] b, input logic last,
                                      input logic flush);
    res_t r;
    r.reply_byte    = b;
    r.reply_last    = last;
    r.flush_request = flush;
    return r;
  endfunction

  function automatic req_t make_req(input logic [1:0] kind, input logic [7:0] b,
                                    input logic [10:0] a);
    req_t r;
    r.req_type     = kind;
    r.rx_byte      = b;
    r.preload_addr = a;
    return r;
  endfunction

  // a page can be read only once all eight of its bytes hold data
  function automatic bit page_known(input logic [7:0] pg);
    for (int k = 0; k < 8; k++)
      if (!shadow_known[STORE_AW'(int'(pg) * 8 + k)]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_read_page();
    logic [7:0] pg;
    pg = 8'($urandom);
    for (int t = 0; t < 256; t++) begin
      if (page_known(pg)) break;
      pg = pg + 8'd1;
    end
    return pg;
  endfunction

  // Shadow responder: updates the shadow state for one request and returns
  // the replies it causes, in strobe order.
  function automatic void compute_replies(input req_t r, ref res_t outs[$]);
    int unsigned base;
    outs.delete();
    case (r.req_type)
      REQ_BYTE: begin
        case (shadow_phase)
          PH_READ_PAGE: begin
            base = int'(r.rx_byte) * 8;
            for (int k = 0; k < 8; k++)
              outs.push_back(make_reply(shadow_store[STORE_AW'(base + k)],
                                        k == 7, 1'b0));
            shadow_phase = PH_IDLE;
          end
          PH_WRITE_PAGE: begin
            shadow_page  = r.rx_byte;
            shadow_index = '0;
            shadow_phase = PH_WRITE_DATA;
          end
          PH_WRITE_DATA: begin
            base = int'(shadow_page) * 8 + int'(shadow_index);
            shadow_store[STORE_AW'(base)] = r.rx_byte;
            shadow_known[STORE_AW'(base)] = 1'b1;
            if (shadow_index == 3'd7) begin
              shadow_index = '0;
              shadow_phase = PH_IDLE;
              outs.push_back(make_reply(8'h00, 1'b1, 1'b0));
            end else begin
              shadow_index = shadow_index + 3'd1;
            end
          end
          default: begin
            // awaiting a command; unknown bytes leave everything alone
            if (r.rx_byte == CMD_READ) begin
              shadow_idle  = '0;
              shadow_phase = PH_READ_PAGE;
            end else if (r.rx_byte == CMD_WRITE) begin
              // dirty as soon as the write command shows up
              shadow_idle  = '0;
              shadow_dirty = 1'b1;
              shadow_phase = PH_WRITE_PAGE;
            end else if (r.rx_byte == CMD_ID0 || r.rx_byte == CMD_ID1) begin
              shadow_idle = '0;
              outs.push_back(make_reply(shadow_id[23:16], 1'b0, 1'b0));
              outs.push_back(make_reply(shadow_id[15:8], 1'b0, 1'b0));
              outs.push_back(make_reply(shadow_id[7:0], 1'b1, 1'b0));
            end
          end
        endcase
      end
      REQ_TICK: begin
        // ticks only count while no command is in flight
        if (shadow_phase == PH_IDLE) begin
          shadow_idle = shadow_idle + 32'd1;
          if (shadow_idle >= shadow_ticks) begin
            shadow_idle = '0;
            if (shadow_dirty) begin
              shadow_dirty = 1'b0;
              outs.push_back(make_reply(8'h00, 1'b0, 1'b1));
            end
          end
        end
      end
      REQ_PRELOAD: begin
        shadow_store[STORE_AW'(r.preload_addr)] = r.rx_byte;
        shadow_known[STORE_AW'(r.preload_addr)] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Drive one request and wait for the handshake. Called and returns on a
  // falling edge. Random gaps, while gaps_on is set, drop start before the request goes out.
  task automatic issue(input req_t r, input int typed_n, input logic [23:0] typed_bytes,
                       input logic typed_flush);
    res_t got [$];
    while (gaps_on && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    compute_replies(r, got);
    if (typed_n == BY_PREDICTION) begin
      foreach (got[k]) pending_replies.push_back(got[k]);
    end else begin
      for (int k = 0; k < typed_n; k++)
        pending_replies.push_back(make_reply(typed_bytes[8 * (typed_n - 1 - k) +: 8],
                                             (k == typed_n - 1) && !typed_flush,
                                             typed_flush));
    end
    if (r.req_type != REQ_RESERVED) requests_sent++;
    @(negedge clk_i);
  endtask

  // A page byte that would read unwritten store is steered to a written page.
  task automatic issue_plain(input logic [1:0] kind, input logic [7:0] b,
                             input logic [10:0] a);
    req_t r;
    r = make_req(kind, b, a);
    if (kind == REQ_BYTE && shadow_phase == PH_READ_PAGE && !page_known(b))
      r.rx_byte = pick_read_page();
    issue(r, BY_PREDICTION, '0, 1'b0);
  endtask

  // Stop feeding, wait for every queued reply, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    if (addr == ADDR_ID) begin
      shadow_id = value[23:0];
      want      = {8'h00, value[23:0]};
    end else begin
      shadow_ticks = value;
      want         = value;
    end
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    if (addr == ADDR_ID ? prdata[23:0] !== want[23:0] : prdata !== want)
      report($sformatf("read-back of reg @%0d: got %h want %h", addr, prdata, want));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One well-formed command with random content, or some noise.
  task automatic random_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      issue_plain(REQ_BYTE, CMD_READ, 11'($urandom));
      issue_plain(REQ_BYTE, 8'($urandom), 11'($urandom));
    end else if (pick < 45) begin
      // most writes are complete; a few stop short and the next bytes land as data
      n = (pick < 41) ? 8 : $urandom_range(0, 7);
      issue_plain(REQ_BYTE, CMD_WRITE, 11'($urandom));
      issue_plain(REQ_BYTE, 8'($urandom), 11'($urandom));
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 99) < 10)
          issue_plain($urandom_range(0, 1) ? REQ_TICK : REQ_PRELOAD,
                      8'($urandom), 11'($urandom));
        issue_plain(REQ_BYTE, 8'($urandom), 11'($urandom));
      end
    end else if (pick < 55) begin
      issue_plain(REQ_BYTE, $urandom_range(0, 1) ? CMD_ID1 : CMD_ID0, 11'($urandom));
    end else if (pick < 78) begin
      n = $urandom_range(1, 4);
      repeat (n) issue_plain(REQ_TICK, 8'($urandom), 11'($urandom));
    end else if (pick < 88) begin
      issue_plain(REQ_PRELOAD, 8'($urandom), 11'($urandom));
    end else if (pick < 95) begin
      issue_plain(REQ_BYTE, 8'($urandom), 11'($urandom));
    end else begin
      issue_plain(REQ_RESERVED, 8'($urandom), 11'($urandom));
    end
  endtask

  function automatic void add_req(input logic [1:0] kind, input logic [7:0] b,
                                  input logic [10:0] a, input int typed_n,
                                  input logic [23:0] typed_bytes, input logic typed_flush);
    step_t s;
    s.kind        = STEP_REQ;
    s.req         = make_req(kind, b, a);
    s.addr        = '0;
    s.value       = '0;
    s.typed_n     = typed_n;
    s.typed_bytes = typed_bytes;
    s.typed_flush = typed_flush;
    plan.push_back(s);
  endfunction

  function automatic void add_cfg(input logic [2:0] addr, input logic [31:0] value);
    step_t s;
    s.kind        = STEP_CFG;
    s.req         = '0;
    s.addr        = addr;
    s.value       = value;
    s.typed_n     = 0;
    s.typed_bytes = '0;
    s.typed_flush = 1'b0;
    plan.push_back(s);
  endfunction

  // Every strobe must match the oldest queued reply, field by field.
  always @(posedge clk_i) begin : check_replies
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (pending_replies.size() == 0) begin
        report($sformatf("unexpected reply %h", res_o));
      end else begin
        want = pending_replies.pop_front();
        if (res_o.reply_byte !== want.reply_byte)
          report($sformatf("reply_byte %h want %h", res_o.reply_byte, want.reply_byte));
        if (res_o.reply_last !== want.reply_last)
          report($sformatf("reply_last %b want %b", res_o.reply_last, want.reply_last));
        if (res_o.flush_request !== want.flush_request)
          report($sformatf("flush_request %b want %b",
                           res_o.flush_request, want.flush_request));
      end
    end
  end

  initial begin
    shadow_phase = PH_IDLE;
    shadow_page  = '0;
    shadow_index = '0;
    shadow_dirty = 1'b0;
    shadow_idle  = '0;
    shadow_id    = ID_RESET;
    shadow_ticks = TICKS_RESET;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The store comes up undefined: fill the lowest pages first, and later
    // reads only go to pages whose bytes have all been written.
    for (int a = 0; a < PRELOAD_BYTES; a++)
      issue_plain(REQ_PRELOAD, 8'($urandom), 11'(a));

    // Directed table. Default registers are still in place for the first rows.
    add_req(REQ_BYTE, CMD_ID0, '0, 3, ID_RESET, 1'b0);
    add_req(REQ_BYTE, CMD_UNKNOWN, '0, 0, '0, 1'b0);
    add_req(REQ_TICK, 8'hFF, 11'h7FF, 0, '0, 1'b0);
    add_req(REQ_RESERVED, 8'hFF, 11'h7FF, 0, '0, 1'b0);
    add_req(REQ_PRELOAD, 8'h00, 11'h000, 0, '0, 1'b0);
    add_req(REQ_PRELOAD, 8'hFF, 11'h7FF, 0, '0, 1'b0);
    // read of the lowest page
    add_req(REQ_BYTE, CMD_READ, '0, BY_PREDICTION, '0, 1'b0);
    add_req(REQ_BYTE, 8'h00, '0, BY_PREDICTION, '0, 1'b0);
    // write of the top page; a tick mid-command is ignored, a preload is not
    add_req(REQ_BYTE, CMD_WRITE, '0, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'hFF, '0, 0, '0, 1'b0);
    add_req(REQ_TICK, 8'h00, '0, 0, '0, 1'b0);
    add_req(REQ_PRELOAD, 8'h3C, 11'h005, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'h00, '0, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'hFF, '0, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'h01, '0, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'h80, '0, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'h7F, '0, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'hFE, '0, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'h55, '0, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'hAA, '0, 1, 24'h000000, 1'b0);
    // read it back with a tick in between the two bytes
    add_req(REQ_BYTE, CMD_READ, '0, BY_PREDICTION, '0, 1'b0);
    add_req(REQ_TICK, 8'h00, '0, 0, '0, 1'b0);
    add_req(REQ_BYTE, 8'hFF, '0, BY_PREDICTION, '0, 1'b0);
    // zero threshold: the first tick flushes the dirty store, the next finds it clean
    add_cfg(ADDR_TICKS, 32'd0);
    add_req(REQ_TICK, 8'h00, '0, 1, '0, 1'b1);
    add_req(REQ_TICK, 8'h00, '0, 0, '0, 1'b0);
    // identity extremes
    add_cfg(ADDR_ID, 32'h00FF_FFFF);
    add_req(REQ_BYTE, CMD_ID1, '0, 3, 24'hFFFFFF, 1'b0);
    add_cfg(ADDR_ID, 32'h0000_0000);
    add_req(REQ_BYTE, CMD_ID0, '0, 3, 24'h000000, 1'b0);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        drain();
        write_register(plan[i].addr, plan[i].value);
      end else begin
        issue(plan[i].req, plan[i].typed_n, plan[i].typed_bytes, plan[i].typed_flush);
      end
    end

    // Random phases, each under its own register setting; phase 2 runs
    // with no gaps at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      int target;
      drain();
      case (p)
        0: begin
          write_register(ADDR_ID, $urandom);
          write_register(ADDR_TICKS, 32'd1);
        end
        1: begin
          write_register(ADDR_ID, 32'h00FF_FFFF);
          write_register(ADDR_TICKS, $urandom_range(2, 5));
        end
        2: begin
          write_register(ADDR_ID, 32'h0000_0000);
          write_register(ADDR_TICKS, 32'd0);
        end
        3: begin
          write_register(ADDR_ID, $urandom);
          write_register(ADDR_TICKS, 32'hFFFF_FFFF);
        end
        default: begin
          write_register(ADDR_ID, $urandom);
          write_register(ADDR_TICKS, $urandom_range(3, 8));
        end
      endcase
      gaps_on = (p != 2);
      target  = requests_sent + PHASE_ITEMS;
      while (requests_sent < target) random_sequence();
    end

    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
